// ===== rtl/tmi_pkg.sv =====
// Shared constants, types and helpers for the toric minimum-inversion unit.
// No dependencies; every other file imports this package.
`default_nettype none

package tmi_pkg;

  localparam int MAX_LEN = 16;
  localparam int LEN_MIN = 2;
  localparam int LEN_W   = 5;                  // perm_length register width
  localparam int IDX_W   = $clog2(MAX_LEN);    // position / value width
  localparam int CNT_W   = 7;                  // inversion count width

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_INNER,
    ST_ROW
  } tmi_state_t;

  // Loader status for the element presented this cycle
  typedef struct packed {
    logic             last;
    logic             bad;
    logic [CNT_W-1:0] inv;
  } tmi_load_stat_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] r;
    r = raw;
    if (r < LEN_W'(LEN_MIN)) r = LEN_W'(LEN_MIN);
    if (r > LEN_W'(MAX_LEN)) r = LEN_W'(MAX_LEN);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tmi_step_unit.sv =====
// Shared step unit: acc + (L-1) - 2*x, modulo 2^CNT_W, plus running minimum.
// Depends on tmi_pkg.
`default_nettype none

module tmi_step_unit (
  input  wire logic [tmi_pkg::CNT_W-1:0] acc,
  input  wire logic [tmi_pkg::IDX_W-1:0] x,
  input  wire logic [tmi_pkg::IDX_W-1:0] len_m1,
  input  wire logic [tmi_pkg::CNT_W-1:0] best,
  output logic      [tmi_pkg::CNT_W-1:0] sum,
  output logic      [tmi_pkg::CNT_W-1:0] new_best
);
  import tmi_pkg::*;

  // true counts stay in 0..L(L-1)/2, so wrapping arithmetic is exact
  always_comb begin
    sum = acc + CNT_W'(len_m1) - CNT_W'({x, 1'b0});
    new_best = (sum < best) ? sum : best;
  end

endmodule

`default_nettype wire

// ===== rtl/tmi_loader.sv =====
// Element loader: permutation store, value-to-position store, seen mask,
// running inversion count and bad-permutation flag. Depends on tmi_pkg.
`default_nettype none

module tmi_loader (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      clear,
  input  wire logic                      load,
  input  wire logic [tmi_pkg::IDX_W-1:0] element,
  input  wire logic [tmi_pkg::IDX_W-1:0] len_m1,
  input  wire logic [tmi_pkg::IDX_W-1:0] pov_addr,
  input  wire logic [tmi_pkg::IDX_W-1:0] perm_addr,
  output logic      [tmi_pkg::IDX_W-1:0] pov_data,
  output logic      [tmi_pkg::IDX_W-1:0] perm_data,
  output tmi_pkg::tmi_load_stat_t        stat
);
  import tmi_pkg::*;

  logic [IDX_W-1:0] perm_store [MAX_LEN];
  logic [IDX_W-1:0] position_of_value [MAX_LEN];
  logic [MAX_LEN-1:0] seen_mask;
  logic [IDX_W-1:0]   loaded_count;
  logic               bad;
  logic [CNT_W-1:0]   inv;

  logic               good;
  logic [IDX_W:0]     greater;

  // earlier values above the new one are the inversions it closes
  always_comb begin
    greater = '0;
    for (int i = 0; i < MAX_LEN; i++) begin
      greater = greater + (IDX_W+1)'(seen_mask[i] && (IDX_W'(i) > element));
    end
    good      = (element <= len_m1) && !seen_mask[element];
    stat.last = (loaded_count == len_m1);
    stat.bad  = bad || !good;
    stat.inv  = inv + CNT_W'(greater);
  end

  assign pov_data  = position_of_value[pov_addr];
  assign perm_data = perm_store[perm_addr];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      seen_mask    <= '0;
      loaded_count <= '0;
      bad          <= 1'b0;
      inv          <= '0;
    end else if (load) begin
      if (stat.last) begin
        seen_mask    <= '0;
        loaded_count <= '0;
        bad          <= 1'b0;
        inv          <= '0;
      end else begin
        if (good) begin
          seen_mask[element] <= 1'b1;
        end
        loaded_count <= loaded_count + IDX_W'(1);
        bad          <= stat.bad;
        inv          <= stat.inv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !clear) begin
      perm_store[loaded_count] <= element;
      if (good) begin
        position_of_value[element] <= loaded_count;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/toric_min_inversions_unit.sv =====
// Top level of the toric minimum-inversion unit: sequencer over the shared
// step unit. Depends on tmi_pkg, tmi_loader, tmi_step_unit.
//
// Usage:
//   Elements of a permutation of 0..L-1 arrive one per request on start /
//   element, in position order; a request is taken when start is high and
//   busy is low. L comes from perm_length (cfg_valid / cfg_ready / cfg_data),
//   clamped to 2..16; a write drops any partial load. cfg_ready is low while
//   busy or while start is high, so a write never meets an element request.
//   Each non-final element is taken while busy stays low.
//   After the L-th element the sequencer walks every position rotation and,
//   inside it, every value rotation, one step of the shared add/min unit per
//   cycle: L*(L-1) value steps plus L-1 position steps, with busy high
//   throughout; done pulses as busy falls after the last step.
//   A load with a repeated or out-of-range element skips the search: done
//   pulses the cycle after the last element with bad_perm set and
//   min_inversions zero.
//   done marks the result for exactly one cycle; the receiver cannot stall.
//   Reset sets perm_length to 16 and empties the load.
`default_nettype none

module toric_min_inversions_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [tmi_pkg::IDX_W-1:0] element,
  output logic                           done,
  output logic      [tmi_pkg::CNT_W-1:0] min_inversions,
  output logic                           bad_perm,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [tmi_pkg::LEN_W-1:0] cfg_data
);
  import tmi_pkg::*;

  tmi_state_t state, state_next;

  logic [LEN_W-1:0] perm_length;
  logic [LEN_W-1:0] len;
  logic [IDX_W-1:0] len_m1;

  logic [IDX_W-1:0] a, a_next;
  logic [IDX_W-1:0] b, b_next;
  logic [CNT_W-1:0] cur, cur_next;
  logic [CNT_W-1:0] best, best_next;
  logic [CNT_W-1:0] rc, rc_next;
  logic             done_next;
  logic [CNT_W-1:0] min_inversions_next;
  logic             bad_perm_next;

  logic             accept;
  logic             cfg_write;
  logic [IDX_W-1:0] pov_data;
  logic [IDX_W-1:0] perm_data;
  logic [IDX_W-1:0] p;
  tmi_load_stat_t   stat;

  logic [CNT_W-1:0] unit_acc;
  logic [IDX_W-1:0] unit_x;
  logic [CNT_W-1:0] unit_sum;
  logic [CNT_W-1:0] unit_min;

  assign busy      = (state != ST_LOAD);
  assign cfg_ready = !busy && !start;
  assign accept    = start && !busy;
  assign cfg_write = cfg_valid && cfg_ready;
  assign len       = eff_len(perm_length);
  assign len_m1    = IDX_W'(len - LEN_W'(1));

  tmi_loader u_loader (
    .clk       (clk),
    .rst       (rst),
    .clear     (cfg_write),
    .load      (accept),
    .element   (element),
    .len_m1    (len_m1),
    .pov_addr  (b),
    .perm_addr (a),
    .pov_data  (pov_data),
    .perm_data (perm_data),
    .stat      (stat)
  );

  tmi_step_unit u_step (
    .acc      (unit_acc),
    .x        (unit_x),
    .len_m1   (len_m1),
    .best     (best),
    .sum      (unit_sum),
    .new_best (unit_min)
  );

  // position of value b after rotating positions left by a
  always_comb begin
    if (pov_data >= a) begin
      p = pov_data - a;
    end else begin
      p = IDX_W'({1'b0, pov_data} + len - {1'b0, a});
    end
  end

  always_comb begin
    state_next          = state;
    a_next              = a;
    b_next              = b;
    cur_next            = cur;
    best_next           = best;
    rc_next             = rc;
    done_next           = 1'b0;
    min_inversions_next = min_inversions;
    bad_perm_next       = bad_perm;
    unit_acc            = cur;
    unit_x              = p;
    case (state)
      ST_LOAD: begin
        if (accept && stat.last && !cfg_write) begin
          if (stat.bad) begin
            done_next           = 1'b1;
            min_inversions_next = '0;
            bad_perm_next       = 1'b1;
          end else begin
            cur_next   = stat.inv;
            best_next  = stat.inv;
            rc_next    = stat.inv;
            a_next     = '0;
            b_next     = '0;
            state_next = ST_INNER;
          end
        end
      end
      ST_INNER: begin
        // smallest value becomes largest
        cur_next  = unit_sum;
        best_next = unit_min;
        if (b == len_m1 - IDX_W'(1)) begin
          b_next = '0;
          if (a == len_m1) begin
            done_next           = 1'b1;
            min_inversions_next = unit_min;
            bad_perm_next       = 1'b0;
            state_next          = ST_LOAD;
          end else begin
            state_next = ST_ROW;
          end
        end else begin
          b_next = b + IDX_W'(1);
        end
      end
      ST_ROW: begin
        // leading element moves to the back
        unit_acc   = rc;
        unit_x     = perm_data;
        rc_next    = unit_sum;
        cur_next   = unit_sum;
        best_next  = unit_min;
        a_next     = a + IDX_W'(1);
        state_next = ST_INNER;
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      done        <= 1'b0;
      perm_length <= LEN_W'(MAX_LEN);
    end else begin
      state <= state_next;
      done  <= done_next;
      if (cfg_write) begin
        perm_length <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    a              <= a_next;
    b              <= b_next;
    cur            <= cur_next;
    best           <= best_next;
    rc             <= rc_next;
    min_inversions <= min_inversions_next;
    bad_perm       <= bad_perm_next;
  end

endmodule

`default_nettype wire

// ===== rtl/tmi_checker.sv =====
// Port-level checks for toric_min_inversions_unit, bound to the top level.
// Depends on toric_min_inversions_unit (bind target) and tmi_pkg.
`default_nettype none

module tmi_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      busy,
  input wire logic                      done,
  input wire logic                      bad_perm,
  input wire logic [tmi_pkg::CNT_W-1:0] min_inversions
);
  import tmi_pkg::*;

  // a search that ends always delivers its result
  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("busy dropped without a result");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe on consecutive cycles");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (done && bad_perm) |-> (min_inversions == '0))
    else $error("bad permutation with nonzero count");

endmodule

bind toric_min_inversions_unit tmi_checker u_tmi_checker (.*);

`default_nettype wire

// ===== tb/sv/toric_min_inversions_unit_tb.sv =====
// Self-checking testbench for toric_min_inversions_unit: loads permutations and
// checks the toric minimum-inversion count and bad flag against an in-bench predictor.
// Depends on tmi_pkg and the toric_min_inversions_unit RTL.
`default_nettype none

module toric_min_inversions_unit_tb;
  import tmi_pkg::*;

  localparam int LIMIT       = 400000;
  localparam int SETTLE      = MAX_LEN * MAX_LEN + 8;
  localparam int RAND_ITEMS  = 1350;

  typedef enum int {
    SEQ_GOOD,
    SEQ_BROKEN,
    SEQ_NOISE,
    SEQ_PARTIAL
  } seq_kind_t;

  typedef struct packed {
    logic [CNT_W-1:0] min_inv;
    logic             bad;
  } tally_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  logic [IDX_W-1:0] element;
  logic             done;
  logic [CNT_W-1:0] min_inversions;
  logic             bad_perm;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data;

  // predictor state
  logic [LEN_W-1:0]   len_reg;
  logic [IDX_W-1:0]   perm_slots [MAX_LEN];
  logic [IDX_W-1:0]   value_pos [MAX_LEN];
  logic [MAX_LEN-1:0] values_seen;
  int                 slots_filled;

  tally_t expected_tallies [$];
  tally_t due;
  int     mismatches;
  int     items_sent;
  int     cycles;
  int     gap_chance;
  bit     quiet_tail;

  toric_min_inversions_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .element        (element),
    .done           (done),
    .min_inversions (min_inversions),
    .bad_perm       (bad_perm),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int active_len();
    int r;
    r = int'(len_reg);
    if (r < LEN_MIN) r = LEN_MIN;
    if (r > MAX_LEN) r = MAX_LEN;
    return r;
  endfunction

  // base count, then position rotations, then value rotations inside each
  function automatic int toric_min(int n);
    int inv, best, cur, p;
    int rot [MAX_LEN];
    inv = 0;
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++)
        if (perm_slots[i] > perm_slots[j]) inv++;
    rot[0] = inv;
    for (int a = 0; a < n - 1; a++)
      rot[a + 1] = rot[a] + n - 1 - 2 * int'(perm_slots[a]);
    best = rot[0];
    for (int a = 0; a < n; a++) begin
      cur = rot[a];
      if (cur < best) best = cur;
      for (int b = 0; b < n - 1; b++) begin
        p = (int'(value_pos[b]) + n - a) % n;
        cur += n - 1 - 2 * p;
        if (cur < best) best = cur;
      end
    end
    return best;
  endfunction

  function automatic void load_element(logic [IDX_W-1:0] v);
    int n, pos;
    tally_t t;
    n = active_len();
    pos = slots_filled;
    if (pos >= n) pos = n - 1;
    perm_slots[pos] = v;
    if (int'(v) < n && !values_seen[v]) begin
      values_seen[v] = 1'b1;
      value_pos[v] = IDX_W'(pos);
    end
    slots_filled = pos + 1;
    if (slots_filled < n) return;
    if ($countones(values_seen) != n) begin
      t.min_inv = '0;
      t.bad = 1'b1;
    end else begin
      t.min_inv = CNT_W'(toric_min(n));
      t.bad = 1'b0;
    end
    expected_tallies.push_back(t);
    slots_filled = 0;
    values_seen = '0;
  endfunction

  function automatic void report_mismatch(string field, int want, int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0d, got %0d", field, want, got);
  endfunction

  // result checker: done cannot be held off
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_tallies.size() == 0) begin
        report_mismatch("unexpected result (min_inversions)", -1, int'(min_inversions));
      end else begin
        due = expected_tallies.pop_front();
        if (min_inversions !== due.min_inv)
          report_mismatch("min_inversions", int'(due.min_inv), int'(min_inversions));
        if (bad_perm !== due.bad)
          report_mismatch("bad_perm", int'(due.bad), int'(bad_perm));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout with %0d results outstanding", expected_tallies.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic idle_gap(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_element(logic [IDX_W-1:0] v);
    start   <= 1'b1;
    element <= v;
    do @(posedge clk); while (busy);
    load_element(v);
    items_sent++;
    if (!quiet_tail && gap_chance != 0 && $urandom_range(1, 8) <= gap_chance)
      idle_gap($urandom_range(1, 16));
  endtask

  task automatic wait_drained();
    if (expected_tallies.size() != 0) begin
      start <= 1'b0;
      while (expected_tallies.size() != 0) @(posedge clk);
    end
  endtask

  // only while idle; a partial load may still be pending, which the write drops
  task automatic write_length(logic [LEN_W-1:0] v);
    start <= 1'b0;
    while (expected_tallies.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    len_reg = v;
    slots_filled = 0;
    values_seen = '0;
  endtask

  task automatic send_perm(seq_kind_t kind);
    logic [IDX_W-1:0] vals [MAX_LEN];
    logic [IDX_W-1:0] tmp;
    int n, cnt, i, j;
    n = active_len();
    for (i = 0; i < n; i++) vals[i] = IDX_W'(i);
    for (i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = vals[i];
      vals[i] = vals[j];
      vals[j] = tmp;
    end
    case (kind)
      SEQ_NOISE: begin
        for (i = 0; i < n; i++) vals[i] = IDX_W'($urandom_range(0, MAX_LEN - 1));
      end
      SEQ_BROKEN: begin
        i = $urandom_range(0, n - 1);
        if (n < MAX_LEN && $urandom_range(0, 1) == 1) begin
          vals[i] = IDX_W'($urandom_range(n, MAX_LEN - 1));
        end else begin
          j = (i + $urandom_range(1, n - 1)) % n;
          vals[i] = vals[j];
        end
      end
      default: ;
    endcase
    cnt = (kind == SEQ_PARTIAL) ? $urandom_range(1, n - 1) : n;
    for (i = 0; i < cnt; i++) send_element(vals[i]);
  endtask

  task automatic send_list(int vals [$]);
    foreach (vals[k]) send_element(IDX_W'(vals[k]));
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return LEN_W'($urandom_range(0, 31));
      1:       return LEN_W'(LEN_MIN);
      2:       return LEN_W'(MAX_LEN);
      default: return LEN_W'($urandom_range(LEN_MIN, MAX_LEN));
    endcase
  endfunction

  // reset length is 16; fully reversed load exercises both element extremes
  task automatic test_default_length();
    send_list('{15, 14, 13, 12, 11, 10, 9, 8, 7, 6, 5, 4, 3, 2, 1, 0});
  endtask

  // out-of-range lengths clamp to 2..16
  task automatic test_length_clamps();
    write_length(5'd31);
    write_length(5'd17);
    write_length(5'd0);
    send_list('{1, 0});
    write_length(5'd1);
    send_list('{0, 1});
  endtask

  task automatic test_bad_perms();
    write_length(5'd3);
    send_list('{0, 3, 1});   // value not below length
    send_list('{2, 2, 0});   // repeated value
  endtask

  task automatic test_partial_discard();
    write_length(5'd4);
    send_list('{3, 1});
    write_length(5'd2);
    send_list('{1, 0});
  endtask

  task automatic test_random_perms();
    int target, tail_from, half, span, since_cfg, r;
    bit paused;
    target    = items_sent + RAND_ITEMS;
    tail_from = items_sent + RAND_ITEMS - 200;
    half      = items_sent + RAND_ITEMS / 2;
    span      = 0;
    since_cfg = 0;
    paused    = 1'b0;
    while (items_sent < target) begin
      if (since_cfg >= span) begin
        if ($urandom_range(0, 3) == 0) send_perm(SEQ_PARTIAL);
        write_length(pick_length());
        since_cfg = 0;
        span = $urandom_range(4, 14);
      end
      if (!paused && items_sent >= half) begin
        wait_drained();
        paused = 1'b1;
      end
      quiet_tail = (items_sent >= tail_from);
      gap_chance = $urandom_range(0, 4);
      r = $urandom_range(0, 99);
      if (r < 80)      send_perm(SEQ_GOOD);
      else if (r < 90) send_perm(SEQ_BROKEN);
      else             send_perm(SEQ_NOISE);
      since_cfg++;
    end
  endtask

  initial begin
    rst          <= 1'b1;
    start        <= 1'b0;
    element      <= '0;
    cfg_valid    <= 1'b0;
    cfg_data     <= '0;
    len_reg      = LEN_W'(MAX_LEN);
    values_seen  = '0;
    slots_filled = 0;
    mismatches   = 0;
    items_sent   = 0;
    cycles       = 0;
    gap_chance   = 2;
    quiet_tail   = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_length();
    test_length_clamps();
    test_bad_perms();
    test_partial_discard();
    test_random_perms();

    wait_drained();
    start <= 1'b0;
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && expected_tallies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
